[rtl/cpu_load_moving_average_core_assert.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the CPU load moving-average core
// Implication and next-cycle implication checks, clocked and reset-gated.
// ----------------------------------------------------------------------------
`ifndef CPU_LOAD_MOVING_AVERAGE_CORE_ASSERT_SVH
`define CPU_LOAD_MOVING_AVERAGE_CORE_ASSERT_SVH

// Same-cycle implication: whenever ante holds, cons holds too.
`define CLA_ASSERT_IMPL(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication: whenever ante holds, cons holds in the following cycle.
`define CLA_ASSERT_NEXT(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/cla_pkg.sv]
// ----------------------------------------------------------------------------
// cla_pkg
// Widths and constants shared by the CPU load moving-average core.
// ----------------------------------------------------------------------------
`default_nettype none

package cla_pkg;

    localparam int NUM_CPUS      = 4;
    localparam int HISTORY_LIMIT = 25;
    localparam int WINDOW        = HISTORY_LIMIT + 1;

    localparam int CPU_IDX_W = 2;
    localparam int TICK_W    = 32;
    localparam int AVG_W     = 7;
    localparam int USED_W    = 34;
    localparam int TOTAL_W   = 35;

    // 100 * used delta, and the divider datapath that holds total delta << 6.
    localparam int PCT_SCALE = 100;
    localparam int NUM_W     = USED_W + AVG_W;
    localparam int DIV_W     = TOTAL_W + AVG_W;

    // 100 = 64 + 32 + 4: taps of the serial multiplier delay line.
    localparam int TAP_A   = 2;
    localparam int TAP_B   = 5;
    localparam int TAP_C   = 6;
    localparam int DLY_LEN = TAP_C;

    localparam int CPU_W      = (NUM_CPUS > 1) ? $clog2(NUM_CPUS) : 1;
    localparam int SLOT_W     = (WINDOW > 1) ? $clog2(WINDOW) : 1;
    localparam int FILL_W     = $clog2(WINDOW + 1);
    localparam int SUM_W      = $clog2(WINDOW * PCT_SCALE + 1);
    localparam int HIST_DEPTH = NUM_CPUS * WINDOW;
    localparam int ADDR_W     = (HIST_DEPTH > 1) ? $clog2(HIST_DEPTH) : 1;
    localparam int BIT_W      = $clog2(NUM_W);
    localparam int STEP_W     = $clog2(AVG_W);

endpackage

`default_nettype wire

[rtl/cla_if.sv]
// ----------------------------------------------------------------------------
// cla_in_if / cla_out_if
// Valid/ready channels for counter samples and averaged load results.
// ----------------------------------------------------------------------------
`default_nettype none

interface cla_in_if;
    import cla_pkg::*;

    logic                 valid;
    logic                 ready;
    logic [CPU_IDX_W-1:0] cpu_index;
    logic [TICK_W-1:0]    user_ticks;
    logic [TICK_W-1:0]    system_ticks;
    logic [TICK_W-1:0]    nice_ticks;
    logic [TICK_W-1:0]    idle_ticks;

    modport source (
        output valid, cpu_index, user_ticks, system_ticks, nice_ticks, idle_ticks,
        input  ready
    );
    modport sink (
        input  valid, cpu_index, user_ticks, system_ticks, nice_ticks, idle_ticks,
        output ready
    );
endinterface

interface cla_out_if;
    import cla_pkg::*;

    logic                 valid;
    logic                 ready;
    logic [CPU_IDX_W-1:0] cpu_index_out;
    logic [AVG_W-1:0]     average_load;
    logic                 bad_delta;

    modport source (
        output valid, cpu_index_out, average_load, bad_delta,
        input  ready
    );
    modport sink (
        input  valid, cpu_index_out, average_load, bad_delta,
        output ready
    );
endinterface

`default_nettype wire

[rtl/cpu_load_moving_average_core.sv]
// ----------------------------------------------------------------------------
// cpu_load_moving_average_core
// Per-CPU busy percentage from cumulative tick counters, averaged over a
// sliding window of recent samples.
// ----------------------------------------------------------------------------
//
//   Channel  Direction  Contents
//   i_in     sink       cpu_index, user/system/nice/idle tick counters
//   o_out    source     cpu_index_out, average_load, bad_delta
//
// An item goes from its transfer to its result being offered through
// the bit-serial pass over NUM_W (41) bits, the busy percentage
// division, the window update, the average division and the load of the
// output register. A bad delta skips the percentage division, and an
// index beyond the core's processors goes straight to the output
// register. The bit-serial pass over the counters takes most of an
// item's time; the next item can be taken in the cycle after the result
// is loaded, so one item is in flight at a time.
// Reset clears the stored counters, window sums, fill counts and slots;
// the history memory is not cleared, since the fill count guards every read.
// A stalled output holds its result while the core goes back to idle and
// takes the next transfer; only loading a second result waits for it.
//
`default_nettype none

module cpu_load_moving_average_core (
    input  logic      i_clk,
    input  logic      i_rst_n,
    cla_in_if.sink    i_in,
    cla_out_if.source o_out
);
    import cla_pkg::*;

    `include "cpu_load_moving_average_core_assert.svh"

    typedef enum logic [5:0] {
        ST_IDLE    = 6'b000001,
        ST_SERIAL  = 6'b000010,
        ST_PCT_DIV = 6'b000100,
        ST_UPDATE  = 6'b001000,
        ST_AVG_DIV = 6'b010000,
        ST_FINISH  = 6'b100000
    } t_state;

    t_state r_state, n_state;

    // Captured sample and per-item working registers.
    logic [CPU_IDX_W-1:0] r_cpu;
    logic [CPU_W-1:0]     r_idx;
    logic [TICK_W-1:0]    r_user, r_sys, r_nice, r_idle;
    logic [USED_W-1:0]    r_pu, r_used_new;
    logic [TOTAL_W-1:0]   r_pt, r_total_new, r_dt;
    logic [ADDR_W-1:0]    r_addr;
    logic                 r_bad;

    // Serial pass: carries, borrows, delta compare and the x100 delay line.
    logic [BIT_W-1:0]     r_bit;
    logic [1:0]           r_c_used;
    logic                 r_c_tot;
    logic                 r_b_du, r_b_dt;
    logic [1:0]           r_c_num;
    logic [DLY_LEN-1:0]   r_du_dly;
    logic                 r_gt, r_nz;

    // Shared restoring divider; r_rem also collects 100 * used delta serially.
    logic [DIV_W-1:0]     r_rem, r_den;
    logic [AVG_W-1:0]     r_quo;
    logic [STEP_W-1:0]    r_step;

    // Per-CPU state.
    logic [USED_W-1:0]    r_prev_used  [NUM_CPUS];
    logic [TOTAL_W-1:0]   r_prev_total [NUM_CPUS];
    logic [SUM_W-1:0]     r_hist_sum   [NUM_CPUS];
    logic [FILL_W-1:0]    r_hist_fill  [NUM_CPUS];
    logic [SLOT_W-1:0]    r_hist_slot  [NUM_CPUS];

    // Window history for all CPUs, one row of WINDOW entries per CPU.
    logic [AVG_W-1:0]     r_hist_mem   [HIST_DEPTH];
    logic [AVG_W-1:0]     r_rd;

    // Output register.
    logic                 r_out_valid;
    logic [CPU_IDX_W-1:0] r_out_cpu;
    logic [AVG_W-1:0]     r_out_avg;
    logic                 r_out_bad;

    logic                 w_in_xfer, w_out_xfer, w_in_range, w_out_free;
    logic [CPU_W-1:0]     w_in_idx;
    logic [2:0]           w_s_used, w_s_num;
    logic [1:0]           w_s_tot;
    logic                 w_used_bit, w_tot_bit, w_du_bit, w_dt_bit;
    logic                 w_ser_last, w_step_last, w_bad_now;
    logic                 w_ge;
    logic [DIV_W-1:0]     w_diff;
    logic                 w_full;
    logic [SUM_W-1:0]     w_sum_new;
    logic [FILL_W-1:0]    w_fill_new;
    logic [SLOT_W-1:0]    w_slot_new;

    assign w_in_xfer  = i_in.valid && i_in.ready;
    assign w_out_xfer = r_out_valid && o_out.ready;
    assign w_out_free = !r_out_valid || o_out.ready;
    assign w_in_idx   = CPU_W'(i_in.cpu_index);
    assign w_in_range = (32'(i_in.cpu_index) < 32'(NUM_CPUS));

    assign i_in.ready          = (r_state == ST_IDLE);
    assign o_out.valid         = r_out_valid;
    assign o_out.cpu_index_out = r_out_cpu;
    assign o_out.average_load  = r_out_avg;
    assign o_out.bad_delta     = r_out_bad;

    // ---- Bit-serial pass, least significant bit first ----------------------
    // used = user + system + nice, total = used + idle, both taken modulo
    // their stored widths; the deltas come out of ripple borrows against the
    // stored counters, and 100 * used delta is formed from three delayed taps.
    assign w_s_used   = {2'b00, r_user[0]} + {2'b00, r_sys[0]} + {2'b00, r_nice[0]}
                      + {1'b0, r_c_used};
    assign w_used_bit = (r_bit < BIT_W'(USED_W)) && w_s_used[0];
    assign w_s_tot    = {1'b0, w_used_bit} + {1'b0, r_idle[0]} + {1'b0, r_c_tot};
    assign w_tot_bit  = (r_bit < BIT_W'(TOTAL_W)) && w_s_tot[0];
    assign w_du_bit   = (r_bit < BIT_W'(USED_W)) && (w_used_bit ^ r_pu[0] ^ r_b_du);
    assign w_dt_bit   = (r_bit < BIT_W'(TOTAL_W)) && (w_tot_bit ^ r_pt[0] ^ r_b_dt);
    assign w_s_num    = {2'b00, r_du_dly[TAP_A-1]} + {2'b00, r_du_dly[TAP_B-1]}
                      + {2'b00, r_du_dly[TAP_C-1]} + {1'b0, r_c_num};
    assign w_ser_last = (r_bit == BIT_W'(NUM_W - 1));

    // The compare is final well before the last serial cycle.
    assign w_bad_now  = !r_nz || r_gt;

    // ---- Divider step --------------------------------------------------------
    assign w_ge        = (r_rem >= r_den);
    assign w_diff      = r_rem - r_den;
    assign w_step_last = (r_step == STEP_W'(AVG_W - 1));

    // ---- Window update -------------------------------------------------------
    // When the window is full, the entry under the slot is the oldest sample
    // and leaves the sum as the new percentage enters.
    assign w_full     = (r_hist_fill[r_idx] == FILL_W'(WINDOW));
    assign w_sum_new  = r_hist_sum[r_idx] - (w_full ? SUM_W'(r_rd) : SUM_W'(0))
                      + SUM_W'(r_quo);
    assign w_fill_new = w_full ? r_hist_fill[r_idx] : r_hist_fill[r_idx] + FILL_W'(1);
    assign w_slot_new = (r_hist_slot[r_idx] == SLOT_W'(WINDOW - 1)) ?
                        SLOT_W'(0) : r_hist_slot[r_idx] + SLOT_W'(1);

    // ---- Sequencer -----------------------------------------------------------
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (w_in_xfer) begin
                    n_state = w_in_range ? ST_SERIAL : ST_FINISH;
                end
            end
            ST_SERIAL: begin
                if (w_ser_last) begin
                    n_state = w_bad_now ? ST_UPDATE : ST_PCT_DIV;
                end
            end
            ST_PCT_DIV: begin
                if (w_step_last) begin
                    n_state = ST_UPDATE;
                end
            end
            ST_UPDATE: begin
                n_state = ST_AVG_DIV;
            end
            ST_AVG_DIV: begin
                if (w_step_last) begin
                    n_state = ST_FINISH;
                end
            end
            ST_FINISH: begin
                if (w_out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // ---- Datapath ------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        case (r_state)
            ST_IDLE: begin
                if (w_in_xfer) begin
                    r_cpu      <= i_in.cpu_index;
                    r_idx      <= w_in_idx;
                    r_user     <= i_in.user_ticks;
                    r_sys      <= i_in.system_ticks;
                    r_nice     <= i_in.nice_ticks;
                    r_idle     <= i_in.idle_ticks;
                    r_bit      <= '0;
                    r_c_used   <= '0;
                    r_c_tot    <= 1'b0;
                    r_b_du     <= 1'b0;
                    r_b_dt     <= 1'b0;
                    r_c_num    <= '0;
                    r_du_dly   <= '0;
                    r_gt       <= 1'b0;
                    r_nz       <= 1'b0;
                    r_rem      <= '0;
                    r_quo      <= '0;
                    r_bad      <= 1'b1;
                    if (w_in_range) begin
                        r_pu   <= r_prev_used[w_in_idx];
                        r_pt   <= r_prev_total[w_in_idx];
                        r_addr <= ADDR_W'(int'(w_in_idx) * WINDOW
                                          + int'(r_hist_slot[w_in_idx]));
                    end
                end
            end
            ST_SERIAL: begin
                r_user   <= r_user >> 1;
                r_sys    <= r_sys >> 1;
                r_nice   <= r_nice >> 1;
                r_idle   <= r_idle >> 1;
                r_pu     <= r_pu >> 1;
                r_pt     <= r_pt >> 1;
                r_c_used <= w_s_used[2:1];
                r_c_tot  <= w_s_tot[1];
                r_b_du   <= (!w_used_bit && (r_pu[0] || r_b_du)) || (r_pu[0] && r_b_du);
                r_b_dt   <= (!w_tot_bit && (r_pt[0] || r_b_dt)) || (r_pt[0] && r_b_dt);
                r_c_num  <= w_s_num[2:1];
                r_du_dly <= {r_du_dly[DLY_LEN-2:0], w_du_bit};
                r_gt     <= (w_du_bit && !w_dt_bit) || (r_gt && (w_du_bit == w_dt_bit));
                r_nz     <= r_nz || w_dt_bit;
                r_bit    <= r_bit + BIT_W'(1);
                if (r_bit < BIT_W'(USED_W)) begin
                    r_used_new <= {w_used_bit, r_used_new[USED_W-1:1]};
                end
                if (r_bit < BIT_W'(TOTAL_W)) begin
                    r_total_new <= {w_tot_bit, r_total_new[TOTAL_W-1:1]};
                    r_dt        <= {w_dt_bit, r_dt[TOTAL_W-1:1]};
                end
                r_rem[NUM_W-1:0]     <= {w_s_num[0], r_rem[NUM_W-1:1]};
                r_rem[DIV_W-1:NUM_W] <= '0;
                if (w_ser_last) begin
                    r_den  <= DIV_W'(r_dt) << (AVG_W - 1);
                    r_step <= '0;
                    r_quo  <= '0;
                    r_bad  <= w_bad_now;
                end
            end
            ST_PCT_DIV, ST_AVG_DIV: begin
                if (w_ge) begin
                    r_rem <= w_diff;
                end
                r_quo  <= {r_quo[AVG_W-2:0], w_ge};
                r_den  <= r_den >> 1;
                r_step <= r_step + STEP_W'(1);
            end
            ST_UPDATE: begin
                r_rem  <= DIV_W'(w_sum_new);
                r_den  <= DIV_W'(w_fill_new) << (AVG_W - 1);
                r_quo  <= '0;
                r_step <= '0;
            end
            default: begin
            end
        endcase
    end

    // Per-CPU counters and window bookkeeping, written once per in-range item.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_CPUS; i++) begin
                r_prev_used[i]  <= '0;
                r_prev_total[i] <= '0;
                r_hist_sum[i]   <= '0;
                r_hist_fill[i]  <= '0;
                r_hist_slot[i]  <= '0;
            end
        end else if (r_state == ST_UPDATE) begin
            r_prev_used[r_idx]  <= r_used_new;
            r_prev_total[r_idx] <= r_total_new;
            r_hist_sum[r_idx]   <= w_sum_new;
            r_hist_fill[r_idx]  <= w_fill_new;
            r_hist_slot[r_idx]  <= w_slot_new;
        end
    end

    // History memory: one write port, one registered read port. The read of
    // the slot being replaced is settled long before the update cycle.
    always_ff @(posedge i_clk) begin
        if (r_state == ST_UPDATE) begin
            r_hist_mem[r_addr] <= r_quo;
        end
        r_rd <= r_hist_mem[r_addr];
    end

    // ---- Output register -----------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (r_state == ST_FINISH && w_out_free) begin
            r_out_valid <= 1'b1;
        end else if (w_out_xfer) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ST_FINISH && w_out_free) begin
            r_out_cpu <= r_cpu;
            r_out_avg <= r_quo;
            r_out_bad <= r_bad;
        end
    end

    // ---- Assertions ----------------------------------------------------------
    `CLA_ASSERT_IMPL(a_pct_in_range, i_clk, i_rst_n, r_state == ST_UPDATE, r_quo <= AVG_W'(PCT_SCALE), "busy percentage above 100")
    `CLA_ASSERT_IMPL(a_num_no_carry, i_clk, i_rst_n, $past(r_state) == ST_SERIAL && r_state != ST_SERIAL, r_c_num == '0, "scaled used delta overflowed")
    `CLA_ASSERT_IMPL(a_avg_den_nonzero, i_clk, i_rst_n, r_state == ST_AVG_DIV, r_den != '0, "average divided by an empty window")
    `CLA_ASSERT_NEXT(a_fill_after_update, i_clk, i_rst_n, r_state == ST_UPDATE, r_hist_fill[r_idx] != '0, "window still empty after update")
    `CLA_ASSERT_IMPL(a_result_from_finish, i_clk, i_rst_n, $rose(r_out_valid), $past(r_state) == ST_FINISH, "result offered outside finish")

endmodule

`default_nettype wire

[dv/tb.sv]
// ----------------------------------------------------------------------------
// tb: testbench for cpu_load_moving_average_core
// Feeds per-CPU tick counter samples through the input channel and checks
// every averaged load result against a cycle-free predictor of the core.
// ----------------------------------------------------------------------------
`default_nettype none

module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import cla_pkg::*;

    // Every index that the 2-bit field can carry, in range or not.
    localparam int     IDX_SPAN     = 1 << CPU_IDX_W;
    localparam int     CLK_HALF     = 5;
    localparam int     RESET_CYCLES = 3;
    localparam int     RANDOM_ITEMS = 1500;
    // Longer than the core's transfer-to-result latency.
    localparam int     DRAIN_CYCLES = 64;
    // The slowest correct run (every sample meeting the longest sender gap,
    // the longest receiver stall and the full latency) stays well below this.
    localparam longint CYCLE_LIMIT  = 1_500_000;
    localparam int     REPORT_MAX   = 10;

    typedef struct packed {
        logic [CPU_IDX_W-1:0] cpu;
        logic [TICK_W-1:0]    user;
        logic [TICK_W-1:0]    sys;
        logic [TICK_W-1:0]    nice;
        logic [TICK_W-1:0]    idle;
    } sample_t;

    typedef struct packed {
        logic [CPU_IDX_W-1:0] cpu;
        logic [AVG_W-1:0]     avg;
        logic                 bad;
    } load_t;

    // ------------------------------------------------------------------------
    // Scoreboard. It keeps its own copy of the per-CPU counters and load
    // windows, works out the averaged load for every accepted sample and
    // holds those loads in order until the core returns its own.
    // ------------------------------------------------------------------------
    class load_scoreboard;
        logic [USED_W-1:0]  prev_used  [NUM_CPUS];
        logic [TOTAL_W-1:0] prev_total [NUM_CPUS];
        logic [AVG_W-1:0]   history    [NUM_CPUS][WINDOW];
        int unsigned        hist_sum   [NUM_CPUS];
        int unsigned        hist_fill  [NUM_CPUS];
        int unsigned        hist_slot  [NUM_CPUS];
        load_t              expected_loads[$];
        int unsigned        mismatches;

        function new();
            for (int c = 0; c < NUM_CPUS; c++) begin
                prev_used[c]  = '0;
                prev_total[c] = '0;
                hist_sum[c]   = 0;
                hist_fill[c]  = 0;
                hist_slot[c]  = 0;
                for (int s = 0; s < WINDOW; s++) begin
                    history[c][s] = '0;
                end
            end
            mismatches = 0;
        endfunction

        function void note_sample(sample_t s);
            int                 c;
            logic [USED_W-1:0]  used;
            logic [USED_W-1:0]  d_used;
            logic [TOTAL_W-1:0] total;
            logic [TOTAL_W-1:0] d_total;
            logic [63:0]        scaled;
            logic [AVG_W-1:0]   pct;
            load_t              load;
            c        = int'(s.cpu);
            load.cpu = s.cpu;
            // A processor that the core does not have leaves all state alone.
            if (c >= NUM_CPUS) begin
                load.avg = '0;
                load.bad = 1'b1;
                expected_loads = {expected_loads, load};
                return;
            end
            // The sums and deltas wrap at the widths of the stored counters,
            // so a counter that goes backwards gives a large modular delta.
            used    = USED_W'(s.user) + USED_W'(s.sys) + USED_W'(s.nice);
            total   = TOTAL_W'(used) + TOTAL_W'(s.idle);
            d_used  = used - prev_used[c];
            d_total = total - prev_total[c];
            prev_used[c]  = used;
            prev_total[c] = total;
            if (d_total == '0 || TOTAL_W'(d_used) > d_total) begin
                pct      = '0;
                load.bad = 1'b1;
            end else begin
                scaled   = (64'(d_used) * 64'(PCT_SCALE)) / 64'(d_total);
                pct      = AVG_W'(scaled);
                load.bad = 1'b0;
            end
            // Once the window is full the oldest sample leaves the sum.
            if (hist_fill[c] >= WINDOW) begin
                hist_sum[c] -= history[c][hist_slot[c]];
            end else begin
                hist_fill[c]++;
            end
            history[c][hist_slot[c]] = pct;
            hist_sum[c] += pct;
            hist_slot[c] = (hist_slot[c] + 1) % WINDOW;
            load.avg = AVG_W'(hist_sum[c] / hist_fill[c]);
            expected_loads = {expected_loads, load};
        endfunction

        function void check_load(load_t got);
            load_t want;
            if (expected_loads.size() == 0) begin
                mismatches++;
                if (mismatches <= REPORT_MAX) begin
                    $display("[sb] unexpected load: cpu %0d avg %0d bad %0b",
                             got.cpu, got.avg, got.bad);
                end
                return;
            end
            want = expected_loads.pop_front();
            if (got.cpu !== want.cpu || got.avg !== want.avg || got.bad !== want.bad) begin
                mismatches++;
                if (mismatches <= REPORT_MAX) begin
                    $display("[sb] load mismatch: cpu %0d/%0d avg %0d/%0d bad %0b/%0b %s",
                             want.cpu, got.cpu, want.avg, got.avg, want.bad, got.bad,
                             "(expected/actual)");
                end
            end
        endfunction
    endclass

    logic           i_clk;
    logic           i_rst_n;
    longint         cycles = 0;
    int unsigned    quiet_left = 0;
    logic [TICK_W-1:0] cnt_user [IDX_SPAN];
    logic [TICK_W-1:0] cnt_sys  [IDX_SPAN];
    logic [TICK_W-1:0] cnt_nice [IDX_SPAN];
    logic [TICK_W-1:0] cnt_idle [IDX_SPAN];
    load_scoreboard sb = new();

    cla_in_if  in_if();
    cla_out_if out_if();

    cpu_load_moving_average_core dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if)
    );

    initial i_clk = 1'b0;
    always #(CLK_HALF) i_clk = ~i_clk;

    // Both channels are sampled at the rising edge, before any of the values
    // scheduled at that edge take effect. The input is noted first so that a
    // prediction always exists before the core could return its result.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (in_if.valid && in_if.ready) begin
                sb.note_sample(sample_t'({in_if.cpu_index, in_if.user_ticks,
                                          in_if.system_ticks, in_if.nice_ticks,
                                          in_if.idle_ticks}));
            end
            if (out_if.valid && out_if.ready) begin
                sb.check_load(load_t'({out_if.cpu_index_out, out_if.average_load,
                                       out_if.bad_delta}));
            end
        end
    end

    // Watchdog: a hung handshake ends the run as a failure.
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("tb: errors");
            $finish;
        end
    end

    // Gap after a transfer on the input side. Mostly none or a short one,
    // now and then a long one, and from time to time a run of back-to-back
    // transfers so that the core also sees a sender that never idles.
    function automatic int unsigned next_gap();
        int unsigned r;
        if (quiet_left != 0) begin
            quiet_left--;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 8) begin
            quiet_left = $urandom_range(10, 40);
        end
        if (r < 55) begin
            return 0;
        end
        if (r < 92) begin
            return $urandom_range(1, 6);
        end
        return $urandom_range(20, 60);
    endfunction

    // Advance of one cumulative counter between two samples: idle, slow,
    // busy, or now and then a jump big enough to wrap the 32-bit counter.
    function automatic logic [TICK_W-1:0] tick_step();
        int unsigned r;
        r = $urandom_range(0, 9);
        if (r == 0) begin
            return '0;
        end
        if (r <= 5) begin
            return TICK_W'($urandom_range(1, 100));
        end
        if (r <= 8) begin
            return TICK_W'($urandom_range(1, 100000));
        end
        return TICK_W'($urandom);
    endfunction

    // Offers one sample, holds it until the core takes it, then idles for a
    // random gap. valid is lowered only when a gap follows, so a sample that
    // is sent straight after keeps valid high without a glitch.
    task automatic drive_sample(input sample_t s);
        int unsigned gap;
        in_if.valid        <= 1'b1;
        in_if.cpu_index    <= s.cpu;
        in_if.user_ticks   <= s.user;
        in_if.system_ticks <= s.sys;
        in_if.nice_ticks   <= s.nice;
        in_if.idle_ticks   <= s.idle;
        do @(posedge i_clk); while (!in_if.ready);
        gap = next_gap();
        if (gap != 0) begin
            in_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // Sends a set of counters for one CPU and remembers them, so that the
    // following samples for that CPU can build on them.
    task automatic send_counts(input int unsigned cpu, input logic [TICK_W-1:0] u,
                               input logic [TICK_W-1:0] s, input logic [TICK_W-1:0] n,
                               input logic [TICK_W-1:0] i);
        sample_t smp;
        cnt_user[cpu] = u;
        cnt_sys[cpu]  = s;
        cnt_nice[cpu] = n;
        cnt_idle[cpu] = i;
        smp.cpu  = CPU_IDX_W'(cpu);
        smp.user = u;
        smp.sys  = s;
        smp.nice = n;
        smp.idle = i;
        drive_sample(smp);
    endtask

    // Output side: long stretches of steady readiness, short stalls, and
    // long stalls that make the core hold a result while it takes the next
    // sample.
    initial begin
        int unsigned mode;
        out_if.ready <= 1'b0;
        do @(posedge i_clk); while (!i_rst_n);
        forever begin
            mode = $urandom_range(0, 99);
            if (mode < 25) begin
                out_if.ready <= 1'b1;
                repeat ($urandom_range(50, 300)) @(posedge i_clk);
            end else if (mode < 85) begin
                out_if.ready <= 1'b0;
                repeat ($urandom_range(1, 4)) @(posedge i_clk);
                out_if.ready <= 1'b1;
                repeat ($urandom_range(1, 8)) @(posedge i_clk);
            end else begin
                out_if.ready <= 1'b0;
                repeat ($urandom_range(20, 90)) @(posedge i_clk);
                out_if.ready <= 1'b1;
                repeat ($urandom_range(1, 4)) @(posedge i_clk);
            end
        end
    end

    initial begin
        int unsigned cpu;
        int unsigned kind;
        for (int c = 0; c < IDX_SPAN; c++) begin
            cnt_user[c] = '0;
            cnt_sys[c]  = '0;
            cnt_nice[c] = '0;
            cnt_idle[c] = '0;
        end
        i_rst_n            <= 1'b0;
        in_if.valid        <= 1'b0;
        in_if.cpu_index    <= '0;
        in_if.user_ticks   <= '0;
        in_if.system_ticks <= '0;
        in_if.nice_ticks   <= '0;
        in_if.idle_ticks   <= '0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed samples. A fresh CPU reporting zeros gives a zero total
        // delta; all-ones counters give the widest sums; dropping back to
        // zero makes both deltas wrap.
        send_counts(0, '0, '0, '0, '0);
        send_counts(0, '1, '1, '1, '1);
        send_counts(0, '0, '0, '0, '0);
        // Fully busy, fully idle, then one third busy.
        send_counts(1, 32'd100, 32'd0, 32'd0, 32'd0);
        send_counts(1, 32'd100, 32'd0, 32'd0, 32'd100);
        send_counts(1, 32'd150, 32'd25, 32'd25, 32'd300);
        // Idle ticks falling while used ticks rise: used delta beyond total.
        send_counts(2, 32'd1000, 32'd0, 32'd0, 32'd1000);
        send_counts(2, 32'd2000, 32'd0, 32'd0, 32'd500);
        // Alternating bit patterns on every field.
        send_counts(2, 32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA);
        send_counts(3, 32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555);
        // A counter set far below the last one, then a one-tick fully busy step.
        send_counts(3, 32'd1, 32'd0, 32'd0, 32'd2);
        send_counts(3, 32'd2, 32'd0, 32'd0, 32'd2);
        // Low, steady load: the mean has to truncate towards zero.
        for (int k = 0; k < 10; k++) begin
            send_counts(3, cnt_user[3] + 32'd1, cnt_sys[3], cnt_nice[3],
                        cnt_idle[3] + 32'd299);
        end

        // Random part. Most samples advance a CPU's counters as a real system
        // would, which fills and wraps every window; the rest repeat the last
        // counters, run them backwards or replace them with noise.
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            cpu  = $urandom_range(0, IDX_SPAN - 1);
            kind = $urandom_range(0, 99);
            if (kind < 78) begin
                send_counts(cpu, cnt_user[cpu] + tick_step(), cnt_sys[cpu] + tick_step(),
                            cnt_nice[cpu] + tick_step(), cnt_idle[cpu] + tick_step());
            end else if (kind < 88) begin
                send_counts(cpu, TICK_W'($urandom), TICK_W'($urandom),
                            TICK_W'($urandom), TICK_W'($urandom));
            end else if (kind < 94) begin
                send_counts(cpu, cnt_user[cpu], cnt_sys[cpu], cnt_nice[cpu], cnt_idle[cpu]);
            end else begin
                send_counts(cpu, cnt_user[cpu] - TICK_W'($urandom_range(0, 5000)),
                            cnt_sys[cpu], cnt_nice[cpu],
                            cnt_idle[cpu] - TICK_W'($urandom_range(0, 5000)));
            end
        end
        in_if.valid <= 1'b0;

        // Wait for every outstanding load, then give the core time to show
        // any result that it should not produce.
        while (sb.expected_loads.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (sb.mismatches == 0 && sb.expected_loads.size() == 0) begin
            $display("tb: clean");
        end else begin
            $display("tb: errors");
        end
        $finish;
    end

endmodule

`default_nettype wire

[filelist.f]
+incdir+rtl
rtl/cla_pkg.sv
rtl/cla_if.sv
rtl/cpu_load_moving_average_core.sv
dv/tb.sv
